>>> src/splp_pkg.sv
package splp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DIST_SHIFT = 32 - FRAC_BITS;
  localparam logic [63:0] INV_FOUR_PI_Q32 = 64'd341782638;
  localparam logic [63:0] ROUND_HALF = 64'd1 << (FRAC_BITS - 1);
  localparam logic [31:0] MAX32 = 32'h7fff_ffff;
  localparam logic [31:0] MIN32 = 32'h8000_0000;

  localparam logic [1:0] OP_MUL  = 2'd0;
  localparam logic [1:0] OP_DIV  = 2'd1;
  localparam logic [1:0] OP_SQRT = 2'd2;

  localparam logic [6:0] MUL_STEPS  = 7'd33;
  localparam logic [6:0] DIV_STEPS  = 7'd64;
  localparam logic [6:0] SQRT_STEPS = 7'd32;

  localparam logic [2:0] REG_KERNEL_LENGTH = 3'd0;
  localparam logic [2:0] REG_CHARGE_PER_CONC = 3'd1;
  localparam logic [2:0] REG_APPLIED_POT = 3'd2;
  localparam logic [2:0] REG_ELEC_BEGIN = 3'd3;
  localparam logic [2:0] REG_ELEC_FINISH = 3'd4;

  localparam logic [3:0] PTYPE_LIQUID = 4'd1;
  localparam logic [3:0] PTYPE_ACTIVE = 4'd3;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_rsp_t;

  typedef struct packed {
    logic        sat;
    logic [31:0] val;
  } sat_val_t;

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    logic [32:0] r;
    r = v[32] ? 33'(-v) : 33'(v);
    return r;
  endfunction

  function automatic sat_val_t from_mag(input logic neg, input logic [63:0] m);
    sat_val_t r;
    r.sat = 1'b0;
    if (neg) begin
      if (m > 64'h8000_0000) begin
        r.sat = 1'b1;
        r.val = MIN32;
      end else begin
        r.val = 32'(-m);
      end
    end else begin
      if (m > 64'h7fff_ffff) begin
        r.sat = 1'b1;
        r.val = MAX32;
      end else begin
        r.val = m[31:0];
      end
    end
    return r;
  endfunction

  function automatic sat_val_t clamp64(input logic signed [63:0] v);
    sat_val_t r;
    r.sat = 1'b0;
    if (v > 64'sh0000_0000_7fff_ffff) begin
      r.sat = 1'b1;
      r.val = MAX32;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r.sat = 1'b1;
      r.val = MIN32;
    end else begin
      r.val = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> src/splp_item_if.sv
interface splp_item_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [3:0]  particle_type;
  logic signed [31:0] cation_conc;
  logic signed [31:0] anion_conc;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic        last_of_group;

  modport source (output valid, kind, particle_type, cation_conc, anion_conc,
                  pos_x, pos_y, pos_z, last_of_group, input ready);
  modport sink (input valid, kind, particle_type, cation_conc, anion_conc,
                pos_x, pos_y, pos_z, last_of_group, output ready);
endinterface

>>> src/splp_result_if.sv
interface splp_result_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] potential;
  logic        saturated;

  modport source (output valid, potential, saturated, input ready);
  modport sink (input valid, potential, saturated, output ready);
endinterface

>>> src/splp_cfg_if.sv
interface splp_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> src/sph_local_potential_accumulator.sv
// Local potential of one particle over a stream of header and neighbor items, Q16.16.
// All products, divisions and the square root run one bit (or bit pair) a cycle
// through a single shared shift-add/subtract unit. Each unit operation runs its steps
// between issue and completion, so an item occupies the block for the sum of its unit
// operations: an active header two multiplies and one division plus the accept, sum
// and finish states (no division when the electrolyte ends are equal), a neighbor
// inside the kernel at most six multiplies, a square root and a division, and a
// neighbor that is ignored or out of range at most four multiplies. An item that ends
// a group then passes an emit state to hand its result over. A finished result sits
// in an output register while the next item is taken.
module sph_local_potential_accumulator import splp_pkg::*; (
  input logic            clk,
  input logic            rst,
  splp_item_if.sink      item,
  splp_result_if.source  result,
  splp_cfg_if.sink       cfg
);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_CMUL  = 5'd1;
  localparam logic [4:0] ST_RMUL  = 5'd2;
  localparam logic [4:0] ST_RDIV  = 5'd3;
  localparam logic [4:0] ST_HSUM  = 5'd4;
  localparam logic [4:0] ST_NCHK  = 5'd5;
  localparam logic [4:0] ST_SQX   = 5'd6;
  localparam logic [4:0] ST_SQY   = 5'd7;
  localparam logic [4:0] ST_SQZ   = 5'd8;
  localparam logic [4:0] ST_HH    = 5'd9;
  localparam logic [4:0] ST_SQRT  = 5'd10;
  localparam logic [4:0] ST_KMUL  = 5'd11;
  localparam logic [4:0] ST_NDIV  = 5'd12;
  localparam logic [4:0] ST_FIN   = 5'd13;
  localparam logic [4:0] ST_EMIT  = 5'd14;

  logic [30:0] kernel_length;
  logic signed [31:0] charge_per_concentration;
  logic signed [31:0] applied_potential;
  logic signed [31:0] electrolyte_begin;
  logic signed [31:0] electrolyte_finish;

  logic [4:0]  state;
  logic        issued;
  logic        kind;
  logic        last;
  logic signed [31:0] cc;
  logic signed [31:0] ca;
  logic signed [31:0] px;
  logic signed [31:0] py;
  logic signed [31:0] pz;
  logic signed [31:0] centre_x;
  logic signed [31:0] centre_y;
  logic signed [31:0] centre_z;
  logic signed [31:0] potential_sum;
  logic        centre_active;
  logic        sat_flag;
  logic signed [31:0] chg;
  logic signed [31:0] ramp;
  logic [63:0] work;
  logic [63:0] sq_sum;
  logic [63:0] radius;
  logic        out_valid;
  logic signed [31:0] out_pot;
  logic        out_sat;

  alu_req_t    alu_req;
  alu_rsp_t    alu_rsp;
  logic [63:0] alu_a;
  logic [63:0] alu_b;
  logic [63:0] alu_res;

  logic signed [32:0] cdiff;
  logic signed [32:0] num;
  logic signed [32:0] den;
  logic [32:0] ax;
  logic [32:0] ay;
  logic [32:0] az;
  logic [32:0] dm;
  logic        chg_neg;
  logic        ramp_neg;
  logic        arith;
  logic        in_xfer;
  sat_val_t    chg_sv;
  sat_val_t    div_sv;
  sat_val_t    hsum_sv;
  sat_val_t    nsum_sv;
  logic signed [63:0] sum_ext;
  logic signed [63:0] q_ext;

  assign cdiff = {cc[31], cc} - {ca[31], ca};
  assign num = {centre_y[31], centre_y} - {electrolyte_begin[31], electrolyte_begin};
  assign den = {electrolyte_finish[31], electrolyte_finish}
             - {electrolyte_begin[31], electrolyte_begin};
  assign ax = mag33({centre_x[31], centre_x} - {px[31], px});
  assign ay = mag33({centre_y[31], centre_y} - {py[31], py});
  assign az = mag33({centre_z[31], centre_z} - {pz[31], pz});
  assign dm = mag33(den);
  assign chg_neg = charge_per_concentration[31] ^ cdiff[32];
  assign ramp_neg = applied_potential[31] ^ num[32];

  assign chg_sv = from_mag(chg_neg, (alu_res + ROUND_HALF) >> FRAC_BITS);
  assign div_sv = from_mag(ramp_neg ^ den[32], alu_res);
  assign hsum_sv = clamp64(64'(chg) + 64'(ramp));
  assign sum_ext = 64'(potential_sum);
  assign q_ext = signed'(alu_res);
  assign nsum_sv = clamp64(chg[31] ? sum_ext + q_ext : sum_ext - q_ext);

  assign arith = (state == ST_CMUL) || (state == ST_RMUL) || (state == ST_RDIV)
              || (state == ST_SQX) || (state == ST_SQY) || (state == ST_SQZ)
              || (state == ST_HH) || (state == ST_SQRT) || (state == ST_KMUL)
              || (state == ST_NDIV);
  assign alu_req.start = arith && !issued;

  always_comb begin
    alu_req.op = OP_MUL;
    alu_a = '0;
    alu_b = '0;
    unique case (state)
      ST_CMUL: begin
        alu_a = 64'(mag33(33'(charge_per_concentration)));
        alu_b = 64'(mag33(cdiff));
      end
      ST_RMUL: begin
        alu_a = 64'(mag33(33'(applied_potential)));
        alu_b = 64'(mag33(num));
      end
      ST_RDIV: begin
        alu_req.op = OP_DIV;
        alu_a = work + 64'(dm >> 1);
        alu_b = 64'(dm);
      end
      ST_SQX: begin
        alu_a = 64'(ax);
        alu_b = 64'(ax);
      end
      ST_SQY: begin
        alu_a = 64'(ay);
        alu_b = 64'(ay);
      end
      ST_SQZ: begin
        alu_a = 64'(az);
        alu_b = 64'(az);
      end
      ST_HH: begin
        alu_a = 64'(kernel_length);
        alu_b = 64'(kernel_length);
      end
      ST_SQRT: begin
        alu_req.op = OP_SQRT;
        alu_a = sq_sum;
      end
      ST_KMUL: begin
        alu_a = 64'(mag33(33'(chg)));
        alu_b = INV_FOUR_PI_Q32;
      end
      ST_NDIV: begin
        alu_req.op = OP_DIV;
        alu_a = work + (radius >> 1);
        alu_b = radius;
      end
      default: begin
        alu_req.op = OP_MUL;
      end
    endcase
  end

  splp_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .req    (alu_req),
    .a      (alu_a),
    .b      (alu_b),
    .rsp    (alu_rsp),
    .result (alu_res)
  );

  assign item.ready = (state == ST_IDLE);
  assign in_xfer = item.valid && item.ready;
  assign cfg.ready = 1'b1;
  assign result.valid = out_valid;
  assign result.potential = out_pot;
  assign result.saturated = out_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_length <= 31'd65536;
      charge_per_concentration <= 32'sd65536;
      applied_potential <= '0;
      electrolyte_begin <= '0;
      electrolyte_finish <= 32'sd65536;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_KERNEL_LENGTH: kernel_length <= cfg.data[30:0];
        REG_CHARGE_PER_CONC: charge_per_concentration <= cfg.data;
        REG_APPLIED_POT: applied_potential <= cfg.data;
        REG_ELEC_BEGIN: electrolyte_begin <= cfg.data;
        REG_ELEC_FINISH: electrolyte_finish <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      kind <= item.kind;
      last <= item.last_of_group;
      cc <= item.cation_conc;
      ca <= item.anion_conc;
      px <= item.pos_x;
      py <= item.pos_y;
      pz <= item.pos_z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      issued <= 1'b0;
      centre_x <= '0;
      centre_y <= '0;
      centre_z <= '0;
      potential_sum <= '0;
      centre_active <= 1'b0;
      sat_flag <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (alu_rsp.done) begin
        issued <= 1'b0;
      end else if (alu_req.start) begin
        issued <= 1'b1;
      end
      if (state == ST_EMIT && (!out_valid || result.ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            if (!item.kind) begin
              sat_flag <= 1'b0;
              centre_x <= item.pos_x;
              centre_y <= item.pos_y;
              centre_z <= item.pos_z;
              potential_sum <= '0;
              centre_active <= (item.particle_type == PTYPE_LIQUID)
                            || (item.particle_type == PTYPE_ACTIVE);
              if ((item.particle_type == PTYPE_LIQUID)
                  || (item.particle_type == PTYPE_ACTIVE)) begin
                state <= ST_CMUL;
              end else begin
                state <= ST_FIN;
              end
            end else if (centre_active && item.particle_type == PTYPE_LIQUID) begin
              state <= ST_NCHK;
            end else begin
              state <= ST_FIN;
            end
          end
        end
        ST_CMUL: begin
          if (alu_rsp.done) begin
            chg <= chg_sv.val;
            if (chg_sv.sat || (kind && sq_sum == 64'd0)) begin
              sat_flag <= 1'b1;
            end
            if (!kind) begin
              state <= ST_RMUL;
            end else if (sq_sum == 64'd0) begin
              if (chg_sv.val[31]) begin
                potential_sum <= MAX32;
              end else if (chg_sv.val != 32'd0) begin
                potential_sum <= MIN32;
              end
              state <= ST_FIN;
            end else begin
              state <= ST_SQRT;
            end
          end
        end
        ST_RMUL: begin
          if (alu_rsp.done) begin
            work <= alu_res;
            if (dm != 33'd0) begin
              state <= ST_RDIV;
            end else begin
              if (alu_res == 64'd0) begin
                ramp <= '0;
              end else begin
                sat_flag <= 1'b1;
                ramp <= ramp_neg ? MIN32 : MAX32;
              end
              state <= ST_HSUM;
            end
          end
        end
        ST_RDIV: begin
          if (alu_rsp.done) begin
            ramp <= div_sv.val;
            if (div_sv.sat) begin
              sat_flag <= 1'b1;
            end
            state <= ST_HSUM;
          end
        end
        ST_HSUM: begin
          potential_sum <= hsum_sv.val;
          if (hsum_sv.sat) begin
            sat_flag <= 1'b1;
          end
          state <= ST_FIN;
        end
        ST_NCHK: begin
          if (ax >= 33'(kernel_length) || ay >= 33'(kernel_length)
              || az >= 33'(kernel_length)) begin
            state <= ST_FIN;
          end else begin
            state <= ST_SQX;
          end
        end
        ST_SQX: begin
          if (alu_rsp.done) begin
            sq_sum <= alu_res;
            state <= ST_SQY;
          end
        end
        ST_SQY: begin
          if (alu_rsp.done) begin
            sq_sum <= sq_sum + alu_res;
            state <= ST_SQZ;
          end
        end
        ST_SQZ: begin
          if (alu_rsp.done) begin
            sq_sum <= sq_sum + alu_res;
            state <= ST_HH;
          end
        end
        ST_HH: begin
          if (alu_rsp.done) begin
            state <= (sq_sum >= alu_res) ? ST_FIN : ST_CMUL;
          end
        end
        ST_SQRT: begin
          if (alu_rsp.done) begin
            radius <= alu_res << DIST_SHIFT;
            state <= ST_KMUL;
          end
        end
        ST_KMUL: begin
          if (alu_rsp.done) begin
            work <= alu_res;
            state <= ST_NDIV;
          end
        end
        ST_NDIV: begin
          if (alu_rsp.done) begin
            potential_sum <= nsum_sv.val;
            if (nsum_sv.sat) begin
              sat_flag <= 1'b1;
            end
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          state <= last ? ST_EMIT : ST_IDLE;
        end
        ST_EMIT: begin
          if (!out_valid || result.ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && (!out_valid || result.ready)) begin
      out_pot <= potential_sum;
      out_sat <= sat_flag;
    end
  end

  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> state != ST_IDLE)
    else $error("accepted item did not start processing");

  a_hdr_clears_sat: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && !item.kind) |=> !sat_flag)
    else $error("header did not clear saturation flag");

  a_done_when_issued: assert property (@(posedge clk) disable iff (rst)
    alu_rsp.done |-> (issued && arith))
    else $error("unit finished with no operation outstanding");

  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    alu_req.start |-> !alu_rsp.busy)
    else $error("operation issued while unit busy");

endmodule

>>> src/splp_alu.sv
module splp_alu import splp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  alu_req_t    req,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output alu_rsp_t    rsp,
  output logic [63:0] result
);

  logic        run;
  logic        done;
  logic [6:0]  cnt;
  logic [1:0]  op;
  logic [63:0] acc;
  logic [63:0] x;
  logic [63:0] y;
  logic [63:0] acc_next;
  logic [63:0] x_next;
  logic [63:0] y_next;
  logic [63:0] shifted;
  logic [63:0] trial;

  always_comb begin
    acc_next = acc;
    x_next = x;
    y_next = y;
    shifted = {acc[62:0], x[63]};
    trial = x + y;
    unique case (op)
      OP_MUL: begin
        acc_next = acc + (y[0] ? x : 64'd0);
        x_next = x << 1;
        y_next = y >> 1;
      end
      OP_DIV: begin
        if (shifted >= y) begin
          acc_next = shifted - y;
          x_next = {x[62:0], 1'b1};
        end else begin
          acc_next = shifted;
          x_next = {x[62:0], 1'b0};
        end
      end
      OP_SQRT: begin
        if (acc >= trial) begin
          acc_next = acc - trial;
          x_next = (x >> 1) + y;
        end else begin
          x_next = x >> 1;
        end
        y_next = y >> 2;
      end
      default: begin
        acc_next = acc;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !run) begin
        run <= 1'b1;
        unique case (req.op)
          OP_MUL: cnt <= MUL_STEPS;
          OP_DIV: cnt <= DIV_STEPS;
          OP_SQRT: cnt <= SQRT_STEPS;
          default: cnt <= 7'd1;
        endcase
      end else if (run) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !run) begin
      op <= req.op;
      unique case (req.op)
        OP_SQRT: begin
          acc <= a;
          x <= '0;
          y <= 64'd1 << 62;
        end
        OP_DIV: begin
          acc <= '0;
          x <= a;
          y <= b;
        end
        default: begin
          acc <= '0;
          x <= a;
          y <= b;
        end
      endcase
    end else if (run) begin
      acc <= acc_next;
      x <= x_next;
      y <= y_next;
    end
  end

  assign rsp.busy = run;
  assign rsp.done = done;
  assign result = (op == OP_MUL) ? acc : x;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import splp_pkg::*;

  typedef struct {
    bit          kind;
    logic [3:0]  ptype;
    logic [31:0] cc;
    logic [31:0] ca;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    bit          last;
    bit          typed;
    logic [31:0] typed_pot;
    bit          typed_sat;
  } particle_row_t;

  typedef struct {
    logic [31:0] pot;
    bit          sat;
  } potential_t;

  logic clk;
  logic rst;

  splp_item_if   item_ch ();
  splp_result_if result_ch ();
  splp_cfg_if    cfg_ch ();

  sph_local_potential_accumulator i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // predictor copy of registers and state
  longint unsigned kern_len;
  longint          chg_per_conc;
  longint          appl_pot;
  longint          elec_begin;
  longint          elec_finish;
  longint          ctr_x;
  longint          ctr_y;
  longint          ctr_z;
  longint          pot_sum;
  bit              ctr_active;
  bit              pred_sat;

  potential_t expected_pots[$];
  int         mismatches;
  bit         failed;
  int         results_seen;
  bit         no_idle;

  function automatic longint sx(logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint unsigned magn(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint saturate_mag(bit neg, longint unsigned m);
    if (neg) begin
      if (m > 64'h8000_0000) begin
        pred_sat = 1'b1;
        return sx(MIN32);
      end
      return -longint'(m);
    end
    if (m > 64'h7fff_ffff) begin
      pred_sat = 1'b1;
      return sx(MAX32);
    end
    return longint'(m);
  endfunction

  function automatic longint clamp_sum(longint v);
    if (v > sx(MAX32)) begin
      pred_sat = 1'b1;
      return sx(MAX32);
    end
    if (v < sx(MIN32)) begin
      pred_sat = 1'b1;
      return sx(MIN32);
    end
    return v;
  endfunction

  function automatic longint charge_density(longint cc, longint ca);
    longint          diff;
    longint unsigned m;
    diff = cc - ca;
    m = magn(chg_per_conc) * magn(diff);
    m = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return saturate_mag((chg_per_conc < 0) != (diff < 0), m);
  endfunction

  function automatic longint applied_ramp(longint y);
    longint          num;
    longint          den;
    longint unsigned nm;
    longint unsigned dm;
    bit              nneg;
    num = y - elec_begin;
    den = elec_finish - elec_begin;
    nm = magn(appl_pot) * magn(num);
    nneg = (appl_pot < 0) != (num < 0);
    dm = magn(den);
    if (dm == 0) begin
      if (nm == 0) return 0;
      pred_sat = 1'b1;
      return nneg ? sx(MIN32) : sx(MAX32);
    end
    return saturate_mag(nneg != (den < 0), (nm + dm / 2) / dm);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic void neighbor_term(particle_row_t it);
    longint unsigned ax, ay, az, s, r, n, d, q;
    longint          c;
    ax = magn(ctr_x - sx(it.px));
    ay = magn(ctr_y - sx(it.py));
    az = magn(ctr_z - sx(it.pz));
    if (ax >= kern_len || ay >= kern_len || az >= kern_len) return;
    s = ax * ax + ay * ay + az * az;
    if (s >= kern_len * kern_len) return;
    r = int_sqrt(s);
    c = charge_density(sx(it.cc), sx(it.ca));
    if (r == 0) begin
      pred_sat = 1'b1;
      if (c > 0) pot_sum = sx(MIN32);
      else if (c < 0) pot_sum = sx(MAX32);
      return;
    end
    n = magn(c) * INV_FOUR_PI_Q32;
    d = r << (32 - FRAC_BITS);
    q = (n + d / 2) / d;
    pot_sum = clamp_sum(c < 0 ? pot_sum + longint'(q) : pot_sum - longint'(q));
  endfunction

  function automatic void predict_potential(particle_row_t it);
    potential_t e;
    if (!it.kind) begin
      pred_sat = 1'b0;
      ctr_x = sx(it.px);
      ctr_y = sx(it.py);
      ctr_z = sx(it.pz);
      ctr_active = (it.ptype == PTYPE_LIQUID || it.ptype == PTYPE_ACTIVE);
      pot_sum = 0;
      if (ctr_active)
        pot_sum = clamp_sum(charge_density(sx(it.cc), sx(it.ca)) + applied_ramp(ctr_y));
    end else if (ctr_active && it.ptype == PTYPE_LIQUID) begin
      neighbor_term(it);
    end
    if (it.last) begin
      e.pot = it.typed ? it.typed_pot : pot_sum[31:0];
      e.sat = it.typed ? it.typed_sat : pred_sat;
      expected_pots.push_back(e);
    end
  endfunction

  function automatic int idle_len();
    if (no_idle) return 0;
    if ($urandom_range(0, 99) < 85) return $urandom_range(0, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_particle(particle_row_t it);
    int g;
    g = idle_len();
    if (g > 0) begin
      item_ch.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    item_ch.valid         <= 1'b1;
    item_ch.kind          <= it.kind;
    item_ch.particle_type <= it.ptype;
    item_ch.cation_conc   <= it.cc;
    item_ch.anion_conc    <= it.ca;
    item_ch.pos_x         <= it.px;
    item_ch.pos_y         <= it.py;
    item_ch.pos_z         <= it.pz;
    item_ch.last_of_group <= it.last;
    do @(posedge clk); while (!item_ch.ready);
    predict_potential(it);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_KERNEL_LENGTH:   kern_len = 64'(val[30:0]);
      REG_CHARGE_PER_CONC: chg_per_conc = sx(val);
      REG_APPLIED_POT:     appl_pot = sx(val);
      REG_ELEC_BEGIN:      elec_begin = sx(val);
      REG_ELEC_FINISH:     elec_finish = sx(val);
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic wait_drained();
    item_ch.valid <= 1'b0;
    while (expected_pots.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_conc();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      2: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
      default: return 32'h0;
    endcase
  endfunction

  function automatic particle_row_t blank_row();
    particle_row_t it;
    it = '{default: '0};
    return it;
  endfunction

  // one well-formed centre with its neighbors, sometimes noise
  task automatic send_group(output int sent);
    particle_row_t hd, nb;
    int          nn;
    int unsigned span, off;
    sent = 0;
    hd = blank_row();
    if ($urandom_range(0, 99) < 8) begin
      hd.kind = 1'($urandom_range(0, 1));
      hd.ptype = 4'($urandom);
      hd.cc = $urandom;
      hd.ca = $urandom;
      hd.px = $urandom;
      hd.py = $urandom;
      hd.pz = $urandom;
      hd.last = 1'($urandom_range(0, 1));
      send_particle(hd);
      sent = 1;
      return;
    end
    hd.ptype = ($urandom_range(0, 99) < 80) ?
               (($urandom_range(0, 1) != 0) ? PTYPE_LIQUID : PTYPE_ACTIVE) : 4'($urandom);
    hd.cc = rand_conc();
    hd.ca = rand_conc();
    hd.px = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0020_0000);
    hd.py = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0020_0000);
    hd.pz = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0020_0000);
    nn = $urandom_range(0, 6);
    hd.last = (nn == 0) || ($urandom_range(0, 9) == 0);
    send_particle(hd);
    sent++;
    span = 32'(kern_len) + 32'(kern_len >> 3) + 2;
    for (int k = 0; k < nn; k++) begin
      nb = blank_row();
      nb.kind = 1'b1;
      nb.ptype = ($urandom_range(0, 99) < 85) ? PTYPE_LIQUID : 4'($urandom);
      nb.cc = rand_conc();
      nb.ca = rand_conc();
      if ($urandom_range(0, 19) == 0) begin
        nb.px = $urandom;
        nb.py = $urandom;
        nb.pz = $urandom;
      end else begin
        off = $urandom_range(0, span);
        nb.px = ($urandom_range(0, 1) != 0) ? hd.px + off : hd.px - off;
        off = $urandom_range(0, span);
        nb.py = ($urandom_range(0, 1) != 0) ? hd.py + off : hd.py - off;
        off = $urandom_range(0, span);
        nb.pz = ($urandom_range(0, 1) != 0) ? hd.pz + off : hd.pz - off;
        if ($urandom_range(0, 29) == 0) begin
          nb.px = hd.px;
          nb.py = hd.py;
          nb.pz = hd.pz;
        end
      end
      nb.last = (k == nn - 1) || ($urandom_range(0, 9) == 0);
      send_particle(nb);
      sent++;
    end
  endtask

  particle_row_t directed_rows[$];

  function automatic particle_row_t mk(bit kind, logic [3:0] pt, logic [31:0] cc,
      logic [31:0] ca, logic [31:0] px, logic [31:0] py, logic [31:0] pz, bit last,
      bit typed = 0, logic [31:0] tpot = 0, bit tsat = 0);
    particle_row_t it;
    it = '{kind, pt, cc, ca, px, py, pz, last, typed, tpot, tsat};
    return it;
  endfunction

  initial begin
    logic [31:0] phase_regs[5];
    int          sent;
    int          phase_items;

    rst = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.kind = 1'b0;
    item_ch.particle_type = '0;
    item_ch.cation_conc = '0;
    item_ch.anion_conc = '0;
    item_ch.pos_x = '0;
    item_ch.pos_y = '0;
    item_ch.pos_z = '0;
    item_ch.last_of_group = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    mismatches = 0;
    failed = 0;
    no_idle = 0;
    kern_len = 65536;
    chg_per_conc = 65536;
    appl_pot = 0;
    elec_begin = 0;
    elec_finish = 65536;
    ctr_x = 0;
    ctr_y = 0;
    ctr_z = 0;
    pot_sum = 0;
    ctr_active = 0;
    pred_sat = 0;

    // neighbor before any header, inactive centres, overflow, zero distance
    directed_rows.push_back(mk(1, PTYPE_LIQUID, 32'h0001_0000, 0, 0, 0, 0, 1, 1, 0, 0));
    directed_rows.push_back(mk(0, 4'd2, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0, 1, 1, 0, 0));
    directed_rows.push_back(mk(0, 4'd15, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                               32'hffff_ffff, 32'hffff_ffff, 1, 1, 0, 0));
    directed_rows.push_back(mk(0, 4'd0, 0, 0, 0, 0, 0, 1, 1, 0, 0));
    directed_rows.push_back(mk(0, PTYPE_LIQUID, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0, 1,
                               1, MAX32, 1));
    directed_rows.push_back(mk(0, PTYPE_LIQUID, 0, 0, 0, 0, 0, 1, 1, 0, 0));
    directed_rows.push_back(mk(1, PTYPE_LIQUID, 32'h0001_0000, 0, 0, 0, 0, 1, 1, MIN32, 1));
    directed_rows.push_back(mk(1, PTYPE_LIQUID, 32'h0001_0000, 0, 32'h4000, 0, 0, 1));
    directed_rows.push_back(mk(0, PTYPE_ACTIVE, 32'h0001_0000, 0, 32'h0010_0000,
                               32'h8000, 0, 0));
    directed_rows.push_back(mk(1, 4'd2, 32'h0100_0000, 0, 32'h0010_0000, 32'h8000, 0, 0));
    directed_rows.push_back(mk(1, PTYPE_LIQUID, 0, 32'h0002_0000, 32'h0010_8000,
                               32'h8000, 0, 0));
    directed_rows.push_back(mk(1, PTYPE_LIQUID, 32'h0003_0000, 0, 32'h0011_0000,
                               32'h8000, 0, 0));
    directed_rows.push_back(mk(1, PTYPE_LIQUID, 32'h0003_0000, 0, 32'h0010_0000,
                               32'h0000_c000, 32'hffff_c000, 1));
    directed_rows.push_back(mk(1, PTYPE_LIQUID, 32'h0000_0100, 0, 32'h0010_0001,
                               32'h8000, 0, 1));
    directed_rows.push_back(mk(0, PTYPE_LIQUID, 32'h8000_0000, 32'h7fff_ffff,
                               32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 1, MIN32, 1));
    directed_rows.push_back(mk(1, PTYPE_LIQUID, 32'h8000_0000, 0, 32'h8000_0000,
                               32'h8000_0000, 32'h8000_0000, 1, 1, MAX32, 1));
    directed_rows.push_back(mk(0, PTYPE_ACTIVE, 32'h0002_0000, 32'h0001_0000, 0,
                               32'h0000_8000, 0, 1));

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) send_particle(directed_rows[i]);

    for (int ph = 0; ph < 8; ph++) begin
      wait_drained();
      case (ph)
        0: phase_regs = '{32'h0001_0000, 32'h0001_0000, 32'h0003_0000, 32'h0, 32'h0010_0000};
        1: phase_regs = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                          32'h7fff_ffff};
        2: phase_regs = '{32'h0, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000};
        3: phase_regs = '{32'h4000, 32'hfff0_0000, 32'h0001_2345, 32'h0005_0000,
                          32'h0005_0000};
        4: phase_regs = '{32'h1, 32'h1, 32'hffff_ffff, 32'h0001_0000, 32'h0001_0000};
        default: begin
          phase_regs[0] = $urandom_range(32'h100, 32'h0020_0000);
          phase_regs[1] = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
          phase_regs[2] = $urandom;
          phase_regs[3] = $urandom_range(0, 32'h0010_0000);
          phase_regs[4] = phase_regs[3] + $urandom_range(1, 32'h0040_0000);
        end
      endcase
      write_reg(REG_KERNEL_LENGTH, phase_regs[0]);
      write_reg(REG_CHARGE_PER_CONC, phase_regs[1]);
      write_reg(REG_APPLIED_POT, phase_regs[2]);
      write_reg(REG_ELEC_BEGIN, phase_regs[3]);
      write_reg(REG_ELEC_FINISH, phase_regs[4]);
      cfg_ch.valid <= 1'b0;
      no_idle = (ph == 2) || (ph == 6);
      phase_items = 0;
      while (phase_items < 130) begin
        send_group(sent);
        phase_items += sent;
      end
    end

    wait_drained();
    if (!failed && expected_pots.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // result side: random back-pressure with one long hold
  initial begin
    bit held;
    held = 0;
    result_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!held && results_seen >= 60) begin
        held = 1;
        result_ch.ready <= 1'b0;
        repeat (3000) @(negedge clk);
      end else if (!no_idle && $urandom_range(0, 99) < 15) begin
        result_ch.ready <= 1'b0;
        repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3))
          @(negedge clk);
      end else begin
        result_ch.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    potential_t e;
    if (rst) begin
      results_seen <= 0;
    end else if (result_ch.valid && result_ch.ready) begin
      results_seen <= results_seen + 1;
      if (expected_pots.size() == 0) begin
        failed = 1;
        if (mismatches < 10)
          $display("unexpected transfer: potential %h saturated %b",
                   result_ch.potential, result_ch.saturated);
        mismatches++;
      end else begin
        e = expected_pots.pop_front();
        if (result_ch.potential !== e.pot || result_ch.saturated !== e.sat) begin
          failed = 1;
          if (mismatches < 10)
            $display("mismatch: potential %h exp %h, saturated %b exp %b",
                     result_ch.potential, e.pot, result_ch.saturated, e.sat);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #50ms;
    $display("FAIL");
    $finish;
  end

endmodule
